/* rtl/core/bsf_pkg.sv */
// Shared types and constants for the byte-stuffing framer codec.
// Used by the front classifier, the job queue, the back emitter and the top level.
package bsf_pkg;

   localparam int JOB_BYTES = 4;
   localparam int JOB_IDX_W = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;
   localparam int QUEUE_CW = 3;

   localparam logic [7:0] BIT5_MASK = 8'h20;
   localparam logic [7:0] FLAG_RESET = 8'd16;
   localparam logic [7:0] ESCAPE_RESET = 8'd27;

   // Configuration register indexes.
   localparam logic CSR_FLAG = 1'b0;
   localparam logic CSR_ESCAPE = 1'b1;

   // Command codes.
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // One classified item: the bytes it emits, in order, and the marks on its final byte.
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [JOB_IDX_W-1:0]      last_idx;
      logic                      frame_end;
      logic                      escape_error;
   } job_type;

endpackage

/* rtl/core/bsf_front.sv */
// Front: holds configuration and decode escape state and turns each accepted
// beat (not a mid-frame decode escape) into 1-4 bytes. Depends on bsf_pkg.
module bsf_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,
   input  logic [1:0]      req_tuser,
   input  logic            req_tlast,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [7:0]      csr_data,
   input  logic            queue_full,
   output logic            push,
   output bsf_pkg::job_type push_job
);
   import bsf_pkg::*;

   logic [7:0] flag_ff, flag_in;
   logic [7:0] escape_ff, escape_in;
   logic       pending_ff, pending_in;

   logic       accept;
   logic       has_result;
   logic       cmd;
   logic       first;
   logic       last;
   logic [7:0] data;
   logic [JOB_IDX_W:0] k;
   job_type    job;

   assign cmd   = req_tuser[0];
   assign first = req_tuser[1];
   assign last  = req_tlast;
   assign data  = req_tdata;

   assign req_tready = !queue_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      job        = '0;
      k          = '0;
      has_result = 1'b0;
      pending_in = pending_ff;
      if (cmd == CMD_ENCODE) begin
         has_result = 1'b1;
         if (first) begin
            job.bytes[k[JOB_IDX_W-1:0]] = flag_ff;
            k = k + 1'b1;
         end
         if (data == flag_ff || data == escape_ff) begin
            job.bytes[k[JOB_IDX_W-1:0]] = escape_ff;
            k = k + 1'b1;
            job.bytes[k[JOB_IDX_W-1:0]] = data ^ BIT5_MASK;
            k = k + 1'b1;
         end else begin
            job.bytes[k[JOB_IDX_W-1:0]] = data;
            k = k + 1'b1;
         end
         if (last) begin
            job.bytes[k[JOB_IDX_W-1:0]] = flag_ff;
            job.frame_end = 1'b1;
            k = k + 1'b1;
         end
         job.last_idx = JOB_IDX_W'(k - 1'b1);
      end else if (pending_ff) begin
         // A byte after an escape is inverted whatever its value.
         has_result     = 1'b1;
         pending_in     = 1'b0;
         job.bytes[0]   = data ^ BIT5_MASK;
         job.frame_end  = last;
      end else if (data == escape_ff) begin
         if (last) begin
            has_result       = 1'b1;
            job.frame_end    = 1'b1;
            job.escape_error = 1'b1;
         end else begin
            pending_in = 1'b1;
         end
      end else begin
         has_result    = 1'b1;
         job.bytes[0]  = data;
         job.frame_end = last;
      end
   end

   assign push     = accept && has_result;
   assign push_job = job;

   always_comb begin
      flag_in   = flag_ff;
      escape_in = escape_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FLAG:   flag_in = csr_data;
            CSR_ESCAPE: escape_in = csr_data;
            default:    flag_in = flag_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff    <= FLAG_RESET;
         escape_ff  <= ESCAPE_RESET;
         pending_ff <= 1'b0;
      end else begin
         flag_ff   <= flag_in;
         escape_ff <= escape_in;
         if (accept) begin
            pending_ff <= pending_in;
         end
      end
   end

endmodule

/* rtl/core/bsf_queue.sv */
// Short job queue between the front and back parts, held in registers.
// Depends on bsf_pkg for the job type and depth.
module bsf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bsf_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output bsf_pkg::job_type head_job
);
   import bsf_pkg::*;

   job_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CW-1:0]  count_ff, count_in;

   assign full       = count_ff == QUEUE_CW'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/core/bsf_back.sv */
// Back part: walks the head job one byte per cycle, while responses do not stall, into the output register.
// Depends on bsf_pkg for the job type.
module bsf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  bsf_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);
   import bsf_pkg::*;

   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 fend_ff, fend_in;
   logic                 err_ff, err_in;
   logic [JOB_IDX_W-1:0] idx_ff, idx_in;
   logic                 load;
   logic                 final_byte;

   // The output register takes a new beat when empty or when its beat is leaving.
   assign load       = !valid_ff || rsp_tready;
   assign final_byte = idx_ff == head_job.last_idx;
   assign pop        = load && head_valid && final_byte;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      fend_in  = fend_ff;
      err_in   = err_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            byte_in = head_job.bytes[idx_ff];
            last_in = final_byte;
            fend_in = final_byte && head_job.frame_end;
            err_in  = final_byte && head_job.escape_error;
            idx_in  = final_byte ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      fend_ff <= fend_in;
      err_ff  <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {err_ff, fend_ff};

endmodule

/* rtl/core/byte_stuffing_framer_codec_unit.sv */
// Byte-stuffing framer and deframer for a serial link: top level.
// Depends on bsf_pkg, bsf_front, bsf_queue and bsf_back.
//
// Each request beat carries one byte and an encode or decode command. Encode wraps
// frames in the flag byte and escapes flag or escape bytes as the escape byte plus
// the byte with bit 5 inverted; decode undoes the escaping and flags a frame that
// ends on a dangling escape. The front classifies a beat in the cycle it is accepted
// and queues one to four output bytes (none for a decoded escape byte that does not
// end the frame); the back sends one byte per cycle while responses do not stall,
// through the single output register. A four-entry job queue lets requests be taken
// back to back while responses stall, until it fills. The user must write
// configuration through the csr port only while the block is idle; the block itself
// does not enforce it.
module byte_stuffing_framer_codec_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [1:0] req_tuser,   // [0] command, [1] frame_first
   input  logic       req_tlast,   // frame_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] frame_end, [1] escape_error
   output logic       rsp_tlast,   // run_last
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);
   import bsf_pkg::*;

   logic    queue_full;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   bsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   bsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   bsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
